>>> rtl/dcas_pkg.sv
`default_nettype none

package dcas_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int CONTEXTS_DEF = 4;

    typedef enum logic [2:0] {
        KIND_RD_REQ  = 3'd0,
        KIND_WR_REQ  = 3'd1,
        KIND_RD_DONE = 3'd2,
        KIND_WR_DONE = 3'd3,
        KIND_TICK    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  context_req;
        logic [63:0] xfer_src;
        logic [63:0] xfer_dst;
        logic [3:0]  done_channel;
    } t_in;

    typedef struct packed {
        logic       granted;
        logic       no_channel;
        logic [3:0] channel;
        logic       switch_valid;
        logic [1:0] switch_context;
    } t_out;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

`default_nettype wire

>>> rtl/dcas_ctrl.sv
`default_nettype none

module dcas_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output dcas_pkg::t_cmd   o_cmd
);
    import dcas_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   exec;

    // The result register may be refilled in the same cycle its beat leaves.
    assign exec = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = exec;

endmodule

`default_nettype wire

>>> rtl/dcas_dp.sv
`default_nettype none

module dcas_dp #(
    parameter int CHANNELS = dcas_pkg::CHANNELS_DEF,
    parameter int CONTEXTS = dcas_pkg::CONTEXTS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  dcas_pkg::t_cmd   i_cmd,
    input  dcas_pkg::t_in    i_in_data,
    output dcas_pkg::t_out   o_out_data
);
    import dcas_pkg::*;

    localparam int CHW = $clog2(CHANNELS);
    localparam int CW  = $clog2(CONTEXTS);

    t_in                 r_in;
    t_out                r_out, n_out;
    logic [CHANNELS-1:0] r_rd_pend, r_wr_pend;
    logic [CHANNELS-1:0] r_rd_wait [CONTEXTS];
    logic [CHANNELS-1:0] r_wr_wait [CONTEXTS];
    logic [CW-1:0]       r_scan, n_scan;

    logic [63:0] rd_src_mem [CHANNELS];
    logic [63:0] rd_dst_mem [CHANNELS];
    logic [63:0] wr_src_mem [CHANNELS];
    logic [63:0] wr_dst_mem [CHANNELS];

    logic                is_read;
    logic [1:0]          ctx_mod;
    logic [CW-1:0]       ctx_idx;
    logic [CHANNELS-1:0] busy, free, low_free;
    logic                any_free;
    logic [CHW-1:0]      chan_idx;
    logic                done_ok;
    logic [CHW-1:0]      done_idx;
    logic [CW-1:0]       scan_c;
    logic                ctx_clear;

    always_comb begin
        is_read = (r_in.kind == KIND_RD_REQ);
        // Context numbers beyond the configured count fold back once.
        if (32'(r_in.context_req) >= CONTEXTS) begin
            ctx_mod = r_in.context_req - 2'(CONTEXTS);
        end else begin
            ctx_mod = r_in.context_req;
        end
        ctx_idx = CW'(ctx_mod);

        busy     = is_read ? r_rd_pend : r_wr_pend;
        free     = ~busy;
        low_free = free & (~free + CHANNELS'(1));
        any_free = |free;
        chan_idx = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (low_free[i]) begin
                chan_idx = chan_idx | CHW'(i);
            end
        end

        done_ok  = (32'(r_in.done_channel) < CHANNELS);
        done_idx = CHW'(r_in.done_channel);

        if (r_scan == '0 || 32'(r_scan) >= CONTEXTS) begin
            scan_c = CW'(1);
        end else begin
            scan_c = r_scan;
        end
        ctx_clear = ((r_rd_wait[scan_c] & r_rd_pend) == '0) &&
                    ((r_wr_wait[scan_c] & r_wr_pend) == '0);
        if (32'(scan_c) + 32'd1 >= CONTEXTS) begin
            n_scan = CW'(1);
        end else begin
            n_scan = scan_c + CW'(1);
        end

        n_out = '0;
        unique case (r_in.kind)
            KIND_RD_REQ, KIND_WR_REQ: begin
                n_out.granted    = any_free;
                n_out.no_channel = !any_free;
                n_out.channel    = any_free ? 4'(chan_idx) : 4'd0;
            end
            KIND_TICK: begin
                n_out.switch_valid   = ctx_clear;
                n_out.switch_context = 2'(scan_c);
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= '0;
            r_wr_pend <= '0;
            for (int k = 0; k < CONTEXTS; k++) begin
                r_rd_wait[k] <= '0;
                r_wr_wait[k] <= '0;
            end
            r_scan <= CW'(1);
        end else if (i_cmd.exec) begin
            unique case (r_in.kind)
                KIND_RD_REQ: begin
                    if (any_free) begin
                        r_rd_pend[chan_idx]  <= 1'b1;
                        r_rd_wait[ctx_idx]   <= r_rd_wait[ctx_idx] | low_free;
                    end
                end
                KIND_WR_REQ: begin
                    if (any_free) begin
                        r_wr_pend[chan_idx]  <= 1'b1;
                        r_wr_wait[ctx_idx]   <= r_wr_wait[ctx_idx] | low_free;
                    end
                end
                KIND_RD_DONE: begin
                    if (done_ok) begin
                        r_rd_pend[done_idx] <= 1'b0;
                    end
                end
                KIND_WR_DONE: begin
                    if (done_ok) begin
                        r_wr_pend[done_idx] <= 1'b0;
                    end
                end
                KIND_TICK: begin
                    r_scan <= n_scan;
                end
                default: begin
                end
            endcase
        end
    end

    // Channel descriptors for the transfer engines.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && any_free) begin
            if (r_in.kind == KIND_RD_REQ) begin
                rd_src_mem[chan_idx] <= r_in.xfer_src;
                rd_dst_mem[chan_idx] <= r_in.xfer_dst;
            end
            if (r_in.kind == KIND_WR_REQ) begin
                wr_src_mem[chan_idx] <= r_in.xfer_src;
                wr_dst_mem[chan_idx] <= r_in.xfer_dst;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

>>> rtl/dma_channel_alloc_ctx_sched_unit.sv
`default_nettype none

// Transfer-channel allocator and context scheduler. Each input beat is a read
// or write channel request, a read or write completion, or a scheduler tick,
// and each produces exactly one result beat. A request takes the lowest free
// channel of its direction and records the addresses in that channel's
// descriptor; a tick checks the next context in rotation over 1..CONTEXTS-1
// and flags it ready when none of its channels is still pending. Other kinds
// yield an all-zero result. The sequencer captures an item in its idle state
// and executes it in its exec state, and takes no new item until the last one
// has executed. The result sits in its own register, so a waiting result does
// not hold up the next input; if that result is still untaken when the next
// item executes, execution waits. No clearing pass is needed after reset.
module dma_channel_alloc_ctx_sched_unit #(
    parameter int CHANNELS = dcas_pkg::CHANNELS_DEF,
    parameter int CONTEXTS = dcas_pkg::CONTEXTS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  dcas_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output dcas_pkg::t_out   o_out_data
);
    import dcas_pkg::*;

    t_cmd cmd;

    dcas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dcas_dp #(
        .CHANNELS (CHANNELS),
        .CONTEXTS (CONTEXTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none

module tb_top;
    import dcas_pkg::*;

    localparam int NUM_CHANNELS = 16;
    localparam int NUM_CONTEXTS = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_LIMIT = 50;
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    // Shadow of the allocator state.
    logic [NUM_CHANNELS-1:0] rd_busy;
    logic [NUM_CHANNELS-1:0] wr_busy;
    logic [NUM_CHANNELS-1:0] rd_waits[NUM_CONTEXTS];
    logic [NUM_CHANNELS-1:0] wr_waits[NUM_CONTEXTS];
    logic [1:0] next_scan_ctx;

    t_out result_q[$];
    int fail_count = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int rx_cycle = 0;

    dma_channel_alloc_ctx_sched_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < PRINT_LIMIT) begin
            $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want) begin
            report_mismatch(what, got, want);
        end
    endtask

    function automatic t_out predict_result(input t_in item);
        t_out r;
        logic [NUM_CHANNELS-1:0] busy;
        int free_ch;
        logic [1:0] c;
        r = '0;
        case (item.kind)
            KIND_RD_REQ, KIND_WR_REQ: begin
                busy = (item.kind == KIND_RD_REQ) ? rd_busy : wr_busy;
                free_ch = -1;
                for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
                    if (!busy[i]) free_ch = i;
                end
                if (free_ch < 0) begin
                    r.no_channel = 1'b1;
                end else begin
                    if (item.kind == KIND_RD_REQ) begin
                        rd_waits[item.context_req][free_ch] = 1'b1;
                        rd_busy[free_ch] = 1'b1;
                    end else begin
                        wr_waits[item.context_req][free_ch] = 1'b1;
                        wr_busy[free_ch] = 1'b1;
                    end
                    r.granted = 1'b1;
                    r.channel = 4'(free_ch);
                end
            end
            KIND_RD_DONE: rd_busy[item.done_channel] = 1'b0;
            KIND_WR_DONE: wr_busy[item.done_channel] = 1'b0;
            KIND_TICK: begin
                // Context zero is never examined; the rotation runs over 1..3.
                c = (next_scan_ctx == 2'd0) ? 2'd1 : next_scan_ctx;
                r.switch_valid = ((rd_waits[c] & rd_busy) == '0) &&
                                 ((wr_waits[c] & wr_busy) == '0);
                r.switch_context = c;
                next_scan_ctx = (c == 2'(NUM_CONTEXTS - 1)) ? 2'd1 : c + 2'd1;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in make_item(input logic [2:0] kind);
        t_in item;
        item.kind = kind;
        item.context_req = 2'($urandom_range(0, NUM_CONTEXTS - 1));
        item.xfer_src = {$urandom, $urandom};
        item.xfer_dst = {$urandom, $urandom};
        item.done_channel = 4'($urandom_range(0, NUM_CHANNELS - 1));
        return item;
    endfunction

    function automatic logic [2:0] pick_kind(input int req_pct, input int done_pct,
                                             input int tick_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < req_pct) begin
            return $urandom_range(0, 1) ? KIND_RD_REQ : KIND_WR_REQ;
        end else if (roll < req_pct + done_pct) begin
            return $urandom_range(0, 1) ? KIND_RD_DONE : KIND_WR_DONE;
        end else if (roll < req_pct + done_pct + tick_pct) begin
            return KIND_TICK;
        end
        return 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    endfunction

    // Valid is lowered only at the start of a gap, so back-to-back beats
    // never see valid dropped and raised in the same step.
    task automatic send_item(input t_in item);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        result_q.push_back(predict_result(item));
        burst_left--;
    endtask

    task automatic test_read_exhaust();
        t_in item;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            item = make_item(KIND_RD_REQ);
            item.context_req = 2'(i % NUM_CONTEXTS);
            item.xfer_src = (i % 2) ? '1 : '0;
            item.xfer_dst = ~item.xfer_src;
            item.done_channel = 4'(i);
            send_item(item);
        end
        // Every read channel is busy now.
        send_item(make_item(KIND_RD_REQ));
    endtask

    task automatic test_completions();
        t_in item;
        item = make_item(KIND_RD_DONE);
        item.done_channel = 4'(NUM_CHANNELS - 1);
        send_item(item);
        // Second completion of a channel that is already free.
        send_item(item);
        item = make_item(KIND_WR_REQ);
        item.context_req = 2'(NUM_CONTEXTS - 1);
        item.xfer_src = '1;
        item.xfer_dst = '1;
        send_item(item);
        item = make_item(KIND_WR_DONE);
        item.done_channel = 4'd0;
        send_item(item);
    endtask

    task automatic test_tick_rotation();
        for (int i = 0; i < NUM_CONTEXTS - 1; i++) begin
            send_item(make_item(KIND_TICK));
        end
    endtask

    task automatic test_unused_kinds();
        send_item(make_item(KIND_UNUSED_LO));
        send_item(make_item(KIND_UNUSED_HI));
    endtask

    task automatic test_random_traffic(input int count, input int req_pct,
                                       input int done_pct, input int tick_pct);
        for (int i = 0; i < count; i++) begin
            send_item(make_item(pick_kind(req_pct, done_pct, tick_pct)));
        end
    endtask

    // Freeing every channel lets the ticks see ready contexts even though
    // waiting masks only ever grow.
    task automatic test_drain_and_scan();
        t_in item;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            item = make_item(KIND_RD_DONE);
            item.done_channel = 4'(ch);
            send_item(item);
            item = make_item(KIND_WR_DONE);
            item.done_channel = 4'(ch);
            send_item(item);
        end
        test_tick_rotation();
    endtask

    task automatic test_pause_until_empty();
        in_valid <= 1'b0;
        do @(posedge clk); while (result_q.size() != 0);
        burst_left = $urandom_range(1, 24);
    endtask

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (result_q.size() == 0) begin
                report_mismatch("result beat with nothing expected", out_data, 0);
            end else begin
                want = result_q.pop_front();
                check_field("granted", out_data.granted, want.granted);
                check_field("no_channel", out_data.no_channel, want.no_channel);
                check_field("channel", out_data.channel, want.channel);
                check_field("switch_valid", out_data.switch_valid, want.switch_valid);
                check_field("switch_context", out_data.switch_context,
                            want.switch_context);
            end
        end
        rx_cycle++;
        case ((rx_cycle / 150) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((rx_cycle % 16) < 8);
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("dma_channel_alloc_ctx_sched_unit: mismatch");
            $finish;
        end
    end

    initial begin
        rd_busy = '0;
        wr_busy = '0;
        for (int i = 0; i < NUM_CONTEXTS; i++) begin
            rd_waits[i] = '0;
            wr_waits[i] = '0;
        end
        next_scan_ctx = 2'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_read_exhaust();
        test_completions();
        test_tick_rotation();
        test_unused_kinds();
        for (int round = 0; round < 5; round++) begin
            test_random_traffic(50, 65, 20, 10);
            test_random_traffic(30, 35, 40, 20);
            test_drain_and_scan();
            if (round == 2) test_pause_until_empty();
        end
        in_valid <= 1'b0;

        while (result_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (result_q.size() != 0) begin
            report_mismatch("results left over", result_q.size(), 0);
        end
        if (fail_count == 0) begin
            $display("dma_channel_alloc_ctx_sched_unit: match");
        end else begin
            $display("dma_channel_alloc_ctx_sched_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
